>>> hw/rtl/wifi_action_per_estimator_unit_assert.svh
// ----------------------------------------------------------------------------
// wifi_action_per_estimator_unit_assert.svh
// Assertion macros for the PER estimator checker. They expect clk and rst_n
// to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef WIFI_ACTION_PER_ESTIMATOR_UNIT_ASSERT_SVH
`define WIFI_ACTION_PER_ESTIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define WAPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WAPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/wape_pkg.sv
// ============================================================================
// wape_pkg
// Types, tables and constants shared by the PER estimator pipeline.
// ============================================================================
`timescale 1ns / 1ps

package wape_pkg;

    localparam int NUM_ACTIONS = 78;
    localparam int MCS_COUNT   = 10;
    localparam int CURVE_PTS   = 14;

    // Effective SNR clamp, centi-dB
    localparam logic signed [14:0] SNR_MIN_CDB = -15'sd1000;
    localparam logic signed [14:0] SNR_MAX_CDB = 15'sd5000;

    localparam logic [9:0]  NSS2_PENALTY = 10'd300;
    localparam logic [16:0] PER_ONE      = 17'd65536;

    // d / 50 for d <= 650: (d * 1311) >> 16
    localparam logic [10:0] K_RECIP  = 11'd1311;
    localparam logic [5:0]  GRID_CDB = 6'd50;

    // per = floor((v * 1024 + 39062) / 78125), estimate via 2^42 / 78125
    localparam logic [25:0] Q_RECIP  = 26'd56294995;
    localparam logic [16:0] Q_DIV    = 17'd78125;
    localparam logic [17:0] Q_DIV_X2 = 18'd156250;
    localparam logic [17:0] Q_BIAS   = 18'd39062;

    typedef struct packed {
        logic [12:0] bits;
        logic [3:0]  mcs;
        logic [1:0]  bw;
        logic [1:0]  nss;
    } act_entry_t;

    // Per-item flags and action fields that ride along the pipeline
    typedef struct packed {
        act_entry_t ent;
        logic       err;
        logic       below;
        logic       above;
    } item_tag_t;

    // Load enables for the two register stages inside one pipeline module
    typedef struct packed {
        logic ld_a;
        logic ld_b;
    } wape_ld_t;

    localparam act_entry_t ACT_ROM [NUM_ACTIONS] = '{
        '{13'd26, 4'd0, 2'd0, 2'd1},   '{13'd52, 4'd0, 2'd0, 2'd2},
        '{13'd52, 4'd1, 2'd0, 2'd1},   '{13'd54, 4'd0, 2'd1, 2'd1},
        '{13'd78, 4'd2, 2'd0, 2'd1},   '{13'd104, 4'd1, 2'd0, 2'd2},
        '{13'd104, 4'd3, 2'd0, 2'd1},  '{13'd108, 4'd0, 2'd1, 2'd2},
        '{13'd108, 4'd1, 2'd1, 2'd1},  '{13'd117, 4'd0, 2'd2, 2'd1},
        '{13'd156, 4'd2, 2'd0, 2'd2},  '{13'd156, 4'd4, 2'd0, 2'd1},
        '{13'd162, 4'd2, 2'd1, 2'd1},  '{13'd208, 4'd3, 2'd0, 2'd2},
        '{13'd208, 4'd5, 2'd0, 2'd1},  '{13'd216, 4'd1, 2'd1, 2'd2},
        '{13'd216, 4'd3, 2'd1, 2'd1},  '{13'd234, 4'd0, 2'd3, 2'd1},
        '{13'd234, 4'd0, 2'd2, 2'd2},  '{13'd234, 4'd1, 2'd2, 2'd1},
        '{13'd234, 4'd6, 2'd0, 2'd1},  '{13'd260, 4'd7, 2'd0, 2'd1},
        '{13'd312, 4'd4, 2'd0, 2'd2},  '{13'd312, 4'd8, 2'd0, 2'd1},
        '{13'd324, 4'd2, 2'd1, 2'd2},  '{13'd324, 4'd4, 2'd1, 2'd1},
        '{13'd351, 4'd2, 2'd2, 2'd1},  '{13'd416, 4'd5, 2'd0, 2'd2},
        '{13'd432, 4'd3, 2'd1, 2'd2},  '{13'd432, 4'd5, 2'd1, 2'd1},
        '{13'd468, 4'd0, 2'd3, 2'd2},  '{13'd468, 4'd1, 2'd3, 2'd1},
        '{13'd468, 4'd1, 2'd2, 2'd2},  '{13'd468, 4'd3, 2'd2, 2'd1},
        '{13'd468, 4'd6, 2'd0, 2'd2},  '{13'd486, 4'd6, 2'd1, 2'd1},
        '{13'd520, 4'd7, 2'd0, 2'd2},  '{13'd540, 4'd7, 2'd1, 2'd1},
        '{13'd624, 4'd8, 2'd0, 2'd2},  '{13'd648, 4'd4, 2'd1, 2'd2},
        '{13'd648, 4'd8, 2'd1, 2'd1},  '{13'd702, 4'd2, 2'd3, 2'd1},
        '{13'd702, 4'd2, 2'd2, 2'd2},  '{13'd702, 4'd4, 2'd2, 2'd1},
        '{13'd720, 4'd9, 2'd1, 2'd1},  '{13'd864, 4'd5, 2'd1, 2'd2},
        '{13'd936, 4'd1, 2'd3, 2'd2},  '{13'd936, 4'd3, 2'd3, 2'd1},
        '{13'd936, 4'd3, 2'd2, 2'd2},  '{13'd936, 4'd5, 2'd2, 2'd1},
        '{13'd972, 4'd6, 2'd1, 2'd2},  '{13'd1053, 4'd6, 2'd2, 2'd1},
        '{13'd1080, 4'd7, 2'd1, 2'd2}, '{13'd1170, 4'd7, 2'd2, 2'd1},
        '{13'd1296, 4'd8, 2'd1, 2'd2}, '{13'd1404, 4'd2, 2'd3, 2'd2},
        '{13'd1404, 4'd4, 2'd3, 2'd1}, '{13'd1404, 4'd4, 2'd2, 2'd2},
        '{13'd1404, 4'd8, 2'd2, 2'd1}, '{13'd1440, 4'd9, 2'd1, 2'd2},
        '{13'd1560, 4'd9, 2'd2, 2'd1}, '{13'd1872, 4'd3, 2'd3, 2'd2},
        '{13'd1872, 4'd5, 2'd3, 2'd1}, '{13'd1872, 4'd5, 2'd2, 2'd2},
        '{13'd2106, 4'd6, 2'd3, 2'd1}, '{13'd2106, 4'd6, 2'd2, 2'd2},
        '{13'd2340, 4'd7, 2'd3, 2'd1}, '{13'd2340, 4'd7, 2'd2, 2'd2},
        '{13'd2808, 4'd4, 2'd3, 2'd2}, '{13'd2808, 4'd8, 2'd3, 2'd1},
        '{13'd2808, 4'd8, 2'd2, 2'd2}, '{13'd3120, 4'd9, 2'd3, 2'd1},
        '{13'd3120, 4'd9, 2'd2, 2'd2}, '{13'd3744, 4'd5, 2'd3, 2'd2},
        '{13'd4212, 4'd6, 2'd3, 2'd2}, '{13'd4680, 4'd7, 2'd3, 2'd2},
        '{13'd5616, 4'd8, 2'd3, 2'd2}, '{13'd6240, 4'd9, 2'd3, 2'd2}
    };

    localparam logic [9:0] BW_PENALTY [4] = '{10'd0, 10'd301, 10'd602, 10'd903};

    // First sample point of each MCS curve, centi-dB
    localparam logic signed [13:0] CURVE_START [MCS_COUNT] = '{
        -14'sd100, 14'sd200, 14'sd450, 14'sd750, 14'sd1100,
        14'sd1450, 14'sd1600, 14'sd1750, 14'sd2100, 14'sd2250
    };

    // Distance from first to last sample point: 50 * (points - 1)
    localparam logic [9:0] CURVE_SPAN [MCS_COUNT] = '{
        10'd450, 10'd400, 10'd450, 10'd500, 10'd450,
        10'd600, 10'd550, 10'd550, 10'd600, 10'd650
    };

    // Curve samples in units of 1e-5, zero padded
    localparam logic [16:0] CURVE_VAL [MCS_COUNT][CURVE_PTS] = '{
        '{17'd100000, 17'd99400, 17'd81850, 17'd29080, 17'd6630, 17'd1120, 17'd150,
          17'd15, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
        '{17'd100000, 17'd99700, 17'd79440, 17'd30080, 17'd7280, 17'd1200, 17'd150,
          17'd23, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
        '{17'd100000, 17'd99800, 17'd75780, 17'd30100, 17'd6760, 17'd1220, 17'd230,
          17'd35, 17'd4, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
        '{17'd100000, 17'd99400, 17'd84050, 17'd43410, 17'd14190, 17'd3740, 17'd860,
          17'd190, 17'd36, 17'd5, 17'd0, 17'd0, 17'd0, 17'd0},
        '{17'd100000, 17'd92690, 17'd51390, 17'd18260, 17'd4650, 17'd1100, 17'd260,
          17'd41, 17'd10, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
        '{17'd100000, 17'd99900, 17'd94790, 17'd66250, 17'd29780, 17'd10580, 17'd3340,
          17'd910, 17'd230, 17'd64, 17'd17, 17'd2, 17'd0, 17'd0},
        '{17'd100000, 17'd99500, 17'd87960, 17'd51390, 17'd20910, 17'd6390, 17'd1860,
          17'd460, 17'd130, 17'd23, 17'd2, 17'd0, 17'd0, 17'd0},
        '{17'd100000, 17'd97850, 17'd73930, 17'd33750, 17'd12340, 17'd3550, 17'd1000,
          17'd270, 17'd50, 17'd9, 17'd1, 17'd0, 17'd0, 17'd0},
        '{17'd100000, 17'd99800, 17'd93990, 17'd67090, 17'd35250, 17'd13760, 17'd4750,
          17'd1540, 17'd520, 17'd150, 17'd36, 17'd7, 17'd0, 17'd0},
        '{17'd100000, 17'd99900, 17'd95060, 17'd68470, 17'd32610, 17'd12480, 17'd4090,
          17'd1300, 17'd360, 17'd82, 17'd10, 17'd2, 17'd1, 17'd0}
    };

endpackage

>>> hw/rtl/wape_lookup.sv
// ============================================================================
// wape_lookup
// Action ROM read, bandwidth/stream penalty, SNR clamp, then offset into the
// MCS curve with below/above range flags.
// ============================================================================
`timescale 1ns / 1ps

module wape_lookup (
    input  logic                    clk,
    input  wape_pkg::wape_ld_t      ld,
    input  logic signed [13:0]      base_snr_cdb,
    input  logic [6:0]              action_number,
    output wape_pkg::item_tag_t     tag,
    output logic [9:0]              d_cdb
);
    import wape_pkg::*;

    // Stage A: ROM and effective SNR
    logic               err_a;
    logic [6:0]         idx_a;
    act_entry_t         ent_a;
    logic [10:0]        pen_a;
    logic signed [14:0] snr_raw_a;
    logic signed [13:0] snr_next;
    act_entry_t         ent_next;
    logic               err_next;

    logic signed [13:0] snr_reg;
    act_entry_t         ent_reg;
    logic               err_reg;

    always_comb
    begin
        err_a = (action_number == 7'd0) || (action_number > 7'(NUM_ACTIONS));
        idx_a = err_a ? 7'd0 : action_number - 7'd1;
        ent_a = err_a ? '0 : ACT_ROM[idx_a];
        pen_a = {1'b0, BW_PENALTY[ent_a.bw]}
              + ((ent_a.nss == 2'd2) ? {1'b0, NSS2_PENALTY} : 11'd0);
        snr_raw_a = {base_snr_cdb[13], base_snr_cdb} - {4'b0, pen_a};
        if (snr_raw_a < SNR_MIN_CDB)
        begin
            snr_next = SNR_MIN_CDB[13:0];
        end
        else if (snr_raw_a > SNR_MAX_CDB)
        begin
            snr_next = SNR_MAX_CDB[13:0];
        end
        else
        begin
            snr_next = snr_raw_a[13:0];
        end
        ent_next = ent_a;
        err_next = err_a;
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_a)
        begin
            snr_reg <= snr_next;
            ent_reg <= ent_next;
            err_reg <= err_next;
        end
    end

    // Stage B: offset from the curve start and range flags
    logic signed [14:0] d_b;
    item_tag_t          tag_next;
    logic [9:0]         d_next;
    item_tag_t          tag_reg;
    logic [9:0]         d_reg;

    always_comb
    begin
        d_b = {snr_reg[13], snr_reg}
            - {CURVE_START[ent_reg.mcs][13], CURVE_START[ent_reg.mcs]};
        tag_next.ent   = ent_reg;
        tag_next.err   = err_reg;
        tag_next.below = d_b[14];
        tag_next.above = !d_b[14] && (d_b[13:0] > {4'b0, CURVE_SPAN[ent_reg.mcs]});
        // out of range: offset is don't-care, keep it zero for safe indexing
        d_next = (tag_next.below || tag_next.above) ? 10'd0 : d_b[9:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_b)
        begin
            tag_reg <= tag_next;
            d_reg   <= d_next;
        end
    end

    assign tag   = tag_reg;
    assign d_cdb = d_reg;

endmodule

>>> hw/rtl/wape_interp.sv
// ============================================================================
// wape_interp
// Splits the curve offset into grid index and remainder, then interpolates
// between neighboring samples (result in units of 2e-7).
// ============================================================================
`timescale 1ns / 1ps

module wape_interp (
    input  logic                    clk,
    input  wape_pkg::wape_ld_t      ld,
    input  wape_pkg::item_tag_t     tag_in,
    input  logic [9:0]              d_cdb,
    output wape_pkg::item_tag_t     tag,
    output logic [22:0]             v_val
);
    import wape_pkg::*;

    // Stage A: k = d / 50, r = d % 50 (d <= 650)
    logic [20:0] kprod_a;
    logic [3:0]  k_next;
    logic [9:0]  k50_a;
    logic [9:0]  rwide_a;
    logic [5:0]  r_next;

    logic [3:0]  k_reg;
    logic [5:0]  r_reg;
    item_tag_t   tag_a_reg;

    always_comb
    begin
        kprod_a = {11'b0, d_cdb} * {10'b0, K_RECIP};
        k_next  = kprod_a[19:16];
        k50_a   = {1'b0, k_next, 5'b0} + {2'b0, k_next, 4'b0} + {5'b0, k_next, 1'b0};
        rwide_a = d_cdb - k50_a;
        r_next  = rwide_a[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_a)
        begin
            k_reg     <= k_next;
            r_reg     <= r_next;
            tag_a_reg <= tag_in;
        end
    end

    // Stage B: v = y[k]*(50-r) + y[k+1]*r
    logic [3:0]  k1_b;
    logic [16:0] y0_b;
    logic [16:0] y1_b;
    logic [5:0]  w0_b;
    logic [22:0] p0_b;
    logic [22:0] p1_b;
    logic [22:0] v_next;

    logic [22:0] v_reg;
    item_tag_t   tag_b_reg;

    always_comb
    begin
        // last point has r = 0, so its neighbor weight is zero
        k1_b   = (k_reg == 4'(CURVE_PTS - 1)) ? k_reg : k_reg + 4'd1;
        y0_b   = CURVE_VAL[tag_a_reg.ent.mcs][k_reg];
        y1_b   = CURVE_VAL[tag_a_reg.ent.mcs][k1_b];
        w0_b   = GRID_CDB - r_reg;
        p0_b   = {6'b0, y0_b} * {17'b0, w0_b};
        p1_b   = {6'b0, y1_b} * {17'b0, r_reg};
        v_next = p0_b + p1_b;
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_b)
        begin
            v_reg     <= v_next;
            tag_b_reg <= tag_a_reg;
        end
    end

    assign tag   = tag_b_reg;
    assign v_val = v_reg;

endmodule

>>> hw/rtl/wape_scale.sv
// ============================================================================
// wape_scale
// Scales the interpolated value to Q1.16 by reciprocal multiply; leaves a
// quotient estimate and its remainder for the final correction.
// ============================================================================
`timescale 1ns / 1ps

module wape_scale (
    input  logic                    clk,
    input  wape_pkg::wape_ld_t      ld,
    input  wape_pkg::item_tag_t     tag_in,
    input  logic [22:0]             v_val,
    output wape_pkg::item_tag_t     tag,
    output logic [16:0]             q_est,
    output logic [17:0]             q_rem
);
    import wape_pkg::*;

    // Stage A: estimate e = floor(v * 2^42 / 78125 / 2^32), low by at most one
    logic [48:0] p_a;
    logic [16:0] e_reg;
    logic [22:0] v_reg;
    item_tag_t   tag_a_reg;

    assign p_a = {26'b0, v_val} * {23'b0, Q_RECIP};

    always_ff @(posedge clk)
    begin
        if (ld.ld_a)
        begin
            e_reg     <= p_a[48:32];
            v_reg     <= v_val;
            tag_a_reg <= tag_in;
        end
    end

    // Stage B: remainder of (v*1024 + bias) - e*78125, below 3 * 78125
    logic [33:0] eprod_b;
    logic [17:0] nlo_b;
    logic [17:0] rem_next;
    logic [16:0] e_b_reg;
    logic [17:0] rem_reg;
    item_tag_t   tag_b_reg;

    always_comb
    begin
        eprod_b  = {17'b0, e_reg} * {17'b0, Q_DIV};
        nlo_b    = {v_reg[7:0], 10'b0} + Q_BIAS;
        rem_next = nlo_b - eprod_b[17:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_b)
        begin
            e_b_reg   <= e_reg;
            rem_reg   <= rem_next;
            tag_b_reg <= tag_a_reg;
        end
    end

    assign tag   = tag_b_reg;
    assign q_est = e_b_reg;
    assign q_rem = rem_reg;

endmodule

>>> hw/rtl/wifi_action_per_estimator_unit.sv
// ============================================================================
// wifi_action_per_estimator_unit
// PER estimate of one rate action at a given base SNR: action ROM, SNR
// penalty and clamp, curve interpolation, Q1.16 rounding.
// ============================================================================
//  channel | handshake                   | payload
//  --------+-----------------------------+----------------------------------
//  query   | query_valid / query_ready   | base_snr_cdb, action_number
//  result  | result_valid / result_ready | per_q16, mcs_used, bandwidth_code,
//          |                             | stream_count, data_bits_per_symbol,
//          |                             | index_error
//
//  Seven register stages; one transfer per cycle in, one per cycle out while result_ready is high.
//  The query is registered in each stage in turn; result_valid rises when it
//  reaches the last stage, and the result transfers while result_ready is high.
//  Each stage holds only while it is full and the stage after it holds, so
//  a stalled result backs up the pipe one stage at a time and bubbles close.
//  Reset clears the stage valid bits only; the data registers are not reset.
// ============================================================================
`timescale 1ns / 1ps

module wifi_action_per_estimator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                query_valid,
    output logic                query_ready,
    input  logic signed [13:0]  base_snr_cdb,
    input  logic [6:0]          action_number,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [16:0]         per_q16,
    output logic [3:0]          mcs_used,
    output logic [1:0]          bandwidth_code,
    output logic [1:0]          stream_count,
    output logic [12:0]         data_bits_per_symbol,
    output logic                index_error
);
    import wape_pkg::*;

    localparam int NUM_STAGES = 7;

    // Stage valid bits and ready chain
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   stage_rdy;

    always_comb
    begin
        stage_rdy[NUM_STAGES] = result_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
        valid_next[0] = stage_rdy[0] ? query_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = stage_rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign query_ready  = stage_rdy[0];
    assign result_valid = valid_reg[NUM_STAGES-1];

    // Stage load enables
    wape_ld_t lk_ld;
    wape_ld_t ip_ld;
    wape_ld_t sc_ld;

    assign lk_ld = '{ld_a: stage_rdy[0], ld_b: stage_rdy[1]};
    assign ip_ld = '{ld_a: stage_rdy[2], ld_b: stage_rdy[3]};
    assign sc_ld = '{ld_a: stage_rdy[4], ld_b: stage_rdy[5]};

    item_tag_t   lk_tag;
    logic [9:0]  lk_d;
    item_tag_t   ip_tag;
    logic [22:0] ip_v;
    item_tag_t   sc_tag;
    logic [16:0] sc_e;
    logic [17:0] sc_rem;

    wape_lookup u_lookup (
        .clk           (clk),
        .ld            (lk_ld),
        .base_snr_cdb  (base_snr_cdb),
        .action_number (action_number),
        .tag           (lk_tag),
        .d_cdb         (lk_d)
    );

    wape_interp u_interp (
        .clk    (clk),
        .ld     (ip_ld),
        .tag_in (lk_tag),
        .d_cdb  (lk_d),
        .tag    (ip_tag),
        .v_val  (ip_v)
    );

    wape_scale u_scale (
        .clk    (clk),
        .ld     (sc_ld),
        .tag_in (ip_tag),
        .v_val  (ip_v),
        .tag    (sc_tag),
        .q_est  (sc_e),
        .q_rem  (sc_rem)
    );

    // Output stage: quotient correction and range selection
    logic [16:0] q_fix;
    logic [16:0] per_next;
    logic [16:0] per_reg;
    act_entry_t  ent_reg;
    logic        err_reg;

    always_comb
    begin
        if (sc_rem >= Q_DIV_X2)
        begin
            q_fix = sc_e + 17'd2;
        end
        else if (sc_rem >= {1'b0, Q_DIV})
        begin
            q_fix = sc_e + 17'd1;
        end
        else
        begin
            q_fix = sc_e;
        end

        if (sc_tag.err || sc_tag.above)
        begin
            per_next = 17'd0;
        end
        else if (sc_tag.below)
        begin
            per_next = PER_ONE;
        end
        else
        begin
            per_next = q_fix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[NUM_STAGES-1])
        begin
            per_reg <= per_next;
            ent_reg <= sc_tag.ent;
            err_reg <= sc_tag.err;
        end
    end

    assign per_q16              = per_reg;
    assign mcs_used             = ent_reg.mcs;
    assign bandwidth_code       = ent_reg.bw;
    assign stream_count         = ent_reg.nss;
    assign data_bits_per_symbol = ent_reg.bits;
    assign index_error          = err_reg;

endmodule

>>> hw/rtl/wape_checker.sv
// ============================================================================
// wape_checker
// Port-level checks on the PER estimator, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "wifi_action_per_estimator_unit_assert.svh"

module wape_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                query_valid,
    input  logic                query_ready,
    input  logic signed [13:0]  base_snr_cdb,
    input  logic [6:0]          action_number,
    input  logic                result_valid,
    input  logic                result_ready,
    input  logic [16:0]         per_q16,
    input  logic [3:0]          mcs_used,
    input  logic [1:0]          bandwidth_code,
    input  logic [1:0]          stream_count,
    input  logic [12:0]         data_bits_per_symbol,
    input  logic                index_error
);

    // A stalled result stays offered
    `WAPE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `WAPE_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(per_q16) && $stable(mcs_used) && $stable(bandwidth_code) && $stable(stream_count) && $stable(data_bits_per_symbol) && $stable(index_error), "result payload changed while stalled")

    // Bad action number clears every other result field
    `WAPE_ASSERT_NOW(a_err_zero, result_valid && index_error, per_q16 == 17'd0 && mcs_used == 4'd0 && bandwidth_code == 2'd0 && stream_count == 2'd0 && data_bits_per_symbol == 13'd0, "index error with nonzero fields")

    // Good action gives a legal PER and ROM fields
    `WAPE_ASSERT_NOW(a_fields_legal, result_valid && !index_error, per_q16 <= 17'd65536 && mcs_used <= 4'd9 && (stream_count == 2'd1 || stream_count == 2'd2) && data_bits_per_symbol != 13'd0, "illegal result fields")

    // MCS 9 never appears at 20 MHz
    `WAPE_ASSERT_NOW(a_no_mcs9_20, result_valid && !index_error && mcs_used == 4'd9, bandwidth_code != 2'd0, "MCS 9 at 20 MHz")

endmodule

bind wifi_action_per_estimator_unit wape_checker u_wape_checker (.*);

>>> test/wifi_action_per_estimator_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// wifi_action_per_estimator_unit_test
// Self-checking bench for the PER estimator. Queries go through a
// valid/ready driver with random gaps. A local model of the action table,
// the SNR penalties and the curve interpolation predicts each result at the
// query transfer. A monitor with random result stalls checks every field in
// order.
// ============================================================================

module wifi_action_per_estimator_unit_test;

    localparam int ACTION_COUNT = 78;
    localparam int GRID         = 50;
    localparam int SNR_FLOOR    = -1000;
    localparam int SNR_CEIL     = 5000;
    localparam int NSS_PENALTY  = 300;
    localparam int PER_FULL     = 65536;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 27;

    // Action table columns
    localparam int COL_BITS = 0;
    localparam int COL_MCS  = 1;
    localparam int COL_BW   = 2;
    localparam int COL_NSS  = 3;

    // bits, mcs, bandwidth code, streams; in rate order
    localparam int ACTION_TAB [ACTION_COUNT][4] = '{
        '{26,0,0,1},   '{52,0,0,2},   '{52,1,0,1},   '{54,0,1,1},   '{78,2,0,1},
        '{104,1,0,2},  '{104,3,0,1},  '{108,0,1,2},  '{108,1,1,1},  '{117,0,2,1},
        '{156,2,0,2},  '{156,4,0,1},  '{162,2,1,1},  '{208,3,0,2},  '{208,5,0,1},
        '{216,1,1,2},  '{216,3,1,1},  '{234,0,3,1},  '{234,0,2,2},  '{234,1,2,1},
        '{234,6,0,1},  '{260,7,0,1},  '{312,4,0,2},  '{312,8,0,1},  '{324,2,1,2},
        '{324,4,1,1},  '{351,2,2,1},  '{416,5,0,2},  '{432,3,1,2},  '{432,5,1,1},
        '{468,0,3,2},  '{468,1,3,1},  '{468,1,2,2},  '{468,3,2,1},  '{468,6,0,2},
        '{486,6,1,1},  '{520,7,0,2},  '{540,7,1,1},  '{624,8,0,2},  '{648,4,1,2},
        '{648,8,1,1},  '{702,2,3,1},  '{702,2,2,2},  '{702,4,2,1},  '{720,9,1,1},
        '{864,5,1,2},  '{936,1,3,2},  '{936,3,3,1},  '{936,3,2,2},  '{936,5,2,1},
        '{972,6,1,2},  '{1053,6,2,1}, '{1080,7,1,2}, '{1170,7,2,1}, '{1296,8,1,2},
        '{1404,2,3,2}, '{1404,4,3,1}, '{1404,4,2,2}, '{1404,8,2,1}, '{1440,9,1,2},
        '{1560,9,2,1}, '{1872,3,3,2}, '{1872,5,3,1}, '{1872,5,2,2}, '{2106,6,3,1},
        '{2106,6,2,2}, '{2340,7,3,1}, '{2340,7,2,2}, '{2808,4,3,2}, '{2808,8,3,1},
        '{2808,8,2,2}, '{3120,9,3,1}, '{3120,9,2,2}, '{3744,5,3,2}, '{4212,6,3,2},
        '{4680,7,3,2}, '{5616,8,3,2}, '{6240,9,3,2}
    };

    localparam int BW_LOSS [4] = '{0, 301, 602, 903};

    localparam int CURVE_X0 [10] = '{-100, 200, 450, 750, 1100, 1450, 1600, 1750, 2100, 2250};
    localparam int CURVE_N  [10] = '{10, 9, 10, 11, 10, 13, 12, 12, 13, 14};

    // PER samples in 1e-5, zero padded to 14 points
    localparam int CURVE_PTS [10][14] = '{
        '{100000, 99400, 81850, 29080, 6630, 1120, 150, 15, 1, 0, 0, 0, 0, 0},
        '{100000, 99700, 79440, 30080, 7280, 1200, 150, 23, 0, 0, 0, 0, 0, 0},
        '{100000, 99800, 75780, 30100, 6760, 1220, 230, 35, 4, 0, 0, 0, 0, 0},
        '{100000, 99400, 84050, 43410, 14190, 3740, 860, 190, 36, 5, 0, 0, 0, 0},
        '{100000, 92690, 51390, 18260, 4650, 1100, 260, 41, 10, 0, 0, 0, 0, 0},
        '{100000, 99900, 94790, 66250, 29780, 10580, 3340, 910, 230, 64, 17, 2, 0, 0},
        '{100000, 99500, 87960, 51390, 20910, 6390, 1860, 460, 130, 23, 2, 0, 0, 0},
        '{100000, 97850, 73930, 33750, 12340, 3550, 1000, 270, 50, 9, 1, 0, 0, 0},
        '{100000, 99800, 93990, 67090, 35250, 13760, 4750, 1540, 520, 150, 36, 7, 0, 0},
        '{100000, 99900, 95060, 68470, 32610, 12480, 4090, 1300, 360, 82, 10, 2, 1, 0}
    };

    typedef struct packed {
        logic signed [13:0] snr;
        logic [6:0]         act;
        logic               drain_first;   // hold until all results are back
    } query_t;

    typedef struct packed {
        logic [16:0] per;
        logic [3:0]  mcs;
        logic [1:0]  bw;
        logic [1:0]  nss;
        logic [12:0] bits;
        logic        err;
    } estimate_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               query_valid = 1'b0;
    logic               query_ready;
    logic signed [13:0] base_snr_cdb = '0;
    logic [6:0]         action_number = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [16:0]        per_q16;
    logic [3:0]         mcs_used;
    logic [1:0]         bandwidth_code;
    logic [1:0]         stream_count;
    logic [12:0]        data_bits_per_symbol;
    logic               index_error;

    query_t    query_q[$];
    estimate_t estimate_q[$];
    int        queries_sent = 0;
    int        mismatches = 0;
    int        cycle_count = 0;
    logic      steady;

    wifi_action_per_estimator_unit dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .query_valid          (query_valid),
        .query_ready          (query_ready),
        .base_snr_cdb         (base_snr_cdb),
        .action_number        (action_number),
        .result_valid         (result_valid),
        .result_ready         (result_ready),
        .per_q16              (per_q16),
        .mcs_used             (mcs_used),
        .bandwidth_code       (bandwidth_code),
        .stream_count         (stream_count),
        .data_bits_per_symbol (data_bits_per_symbol),
        .index_error          (index_error)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // No gaps on either side for a stretch in the middle of the run
    assign steady = (queries_sent >= 700) && (queries_sent < 1000);

    // Expected PER estimate for one query
    function automatic estimate_t estimate_per(logic signed [13:0] snr_in, logic [6:0] act);
        estimate_t est;
        int        row;
        int        m;
        int        eff;
        int        d;
        int        k;
        int        r;
        longint    v;
        est = '0;
        if (act == 0 || act > ACTION_COUNT)
        begin
            est.err = 1'b1;
            return est;
        end
        row      = int'(act) - 1;
        m        = ACTION_TAB[row][COL_MCS];
        est.bits = 13'(ACTION_TAB[row][COL_BITS]);
        est.mcs  = 4'(m);
        est.bw   = 2'(ACTION_TAB[row][COL_BW]);
        est.nss  = 2'(ACTION_TAB[row][COL_NSS]);
        eff = int'(snr_in) - BW_LOSS[ACTION_TAB[row][COL_BW]];
        if (ACTION_TAB[row][COL_NSS] == 2)
            eff = eff - NSS_PENALTY;
        if (eff < SNR_FLOOR)
            eff = SNR_FLOOR;
        if (eff > SNR_CEIL)
            eff = SNR_CEIL;
        d = eff - CURVE_X0[m];
        if (d < 0)
            est.per = 17'(PER_FULL);
        else if (d > GRID * (CURVE_N[m] - 1))
            est.per = '0;
        else
        begin
            // Linear interpolation on the grid, then round to Q1.16
            k = d / GRID;
            r = d % GRID;
            v = longint'(CURVE_PTS[m][k]) * (GRID - r);
            if (r != 0)
                v = v + longint'(CURVE_PTS[m][k + 1]) * r;
            est.per = 17'((v * 65536 + 2500000) / 5000000);
        end
        return est;
    endfunction

    task automatic add_query(int snr, int act, bit drain);
        query_t q;
        q.snr         = 14'(snr);
        q.act         = 7'(act);
        q.drain_first = drain;
        query_q.insert(query_q.size(), q);
    endtask

    // Query driver
    always @(posedge clk or negedge rst_n)
    begin : drive_query
        logic fire;
        logic show;
        query_t nxt;
        if (!rst_n)
        begin
            query_valid <= 1'b0;
        end
        else
        begin
            fire = query_valid && query_ready;
            if (fire)
            begin
                estimate_q.insert(estimate_q.size(),
                                  estimate_per(base_snr_cdb, action_number));
                queries_sent++;
                query_q.delete(0);
            end
            show = query_valid && !fire;
            if (!show && query_q.size() > 0)
            begin
                nxt = query_q[0];
                if (!(nxt.drain_first && estimate_q.size() > 0) &&
                    (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    show = 1'b1;
                    base_snr_cdb  <= nxt.snr;
                    action_number <= nxt.act;
                end
            end
            query_valid <= show;
        end
    end

    // Result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : check_result
        estimate_t exp_est;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (estimate_q.size() == 0)
                begin
                    $error("result transfer with no query outstanding");
                    mismatches++;
                end
                else
                begin
                    exp_est = estimate_q.pop_front();
                    if (per_q16 !== exp_est.per)
                    begin
                        $error("per_q16: expected %0d, got %0d", exp_est.per, per_q16);
                        mismatches++;
                    end
                    if (mcs_used !== exp_est.mcs)
                    begin
                        $error("mcs_used: expected %0d, got %0d", exp_est.mcs, mcs_used);
                        mismatches++;
                    end
                    if (bandwidth_code !== exp_est.bw)
                    begin
                        $error("bandwidth_code: expected %0d, got %0d", exp_est.bw,
                               bandwidth_code);
                        mismatches++;
                    end
                    if (stream_count !== exp_est.nss)
                    begin
                        $error("stream_count: expected %0d, got %0d", exp_est.nss,
                               stream_count);
                        mismatches++;
                    end
                    if (data_bits_per_symbol !== exp_est.bits)
                    begin
                        $error("data_bits_per_symbol: expected %0d, got %0d", exp_est.bits,
                               data_bits_per_symbol);
                        mismatches++;
                    end
                    if (index_error !== exp_est.err)
                    begin
                        $error("index_error: expected %0d, got %0d", exp_est.err,
                               index_error);
                        mismatches++;
                    end
                end
            end
            result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int roll;
        int act;
        int row;
        int m;
        int snr;

        // Table extremes, errors, clamps and curve edges
        add_query(-8192, 1, 1'b0);
        add_query(8191, 1, 1'b0);
        add_query(8191, 78, 1'b0);
        add_query(-8192, 78, 1'b0);
        add_query(0, 0, 1'b0);
        add_query(1234, 79, 1'b0);
        add_query(-1, 127, 1'b0);
        add_query(-100, 1, 1'b0);                 // first curve point
        add_query(-101, 1, 1'b0);                 // just below the curve
        add_query(350, 1, 1'b0);                  // last curve point
        add_query(351, 1, 1'b0);                  // just above the curve
        add_query(0, 1, 1'b0);                    // on the grid
        add_query(23, 1, 1'b0);                   // between grid points
        add_query(3753, 78, 1'b0);                // 160 MHz, two streams
        add_query(810, 18, 1'b0);                 // 160 MHz, one stream
        add_query(200, 2, 1'b0);                  // two-stream penalty
        add_query(3201, 45, 1'b0);                // 40 MHz, last point of MCS 9
        add_query(3802, 72, 1'b0);
        add_query(1000, 10, 1'b0);                // 80 MHz
        add_query(611, 5, 1'b0);
        add_query(1013, 7, 1'b0);
        add_query(1227, 12, 1'b0);
        add_query(1601, 15, 1'b0);
        add_query(1875, 21, 1'b0);
        add_query(2333, 24, 1'b0);

        // Random queries, mostly aimed at the sloped part of each curve
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                act = $urandom_range(1) ? 0 : $urandom_range(127, ACTION_COUNT + 1);
                snr = $urandom;
            end
            else
            begin
                act = $urandom_range(ACTION_COUNT, 1);
                row = act - 1;
                m   = ACTION_TAB[row][COL_MCS];
                if (roll < 70)
                begin
                    snr = CURVE_X0[m] + BW_LOSS[ACTION_TAB[row][COL_BW]]
                        + ((ACTION_TAB[row][COL_NSS] == 2) ? NSS_PENALTY : 0)
                        + $urandom_range(GRID * (CURVE_N[m] - 1) + 120) - 60;
                end
                else
                begin
                    snr = $urandom;
                end
            end
            add_query(snr, act, (i == 0) || (i == 400));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (query_q.size() > 0 || query_valid)
            @(posedge clk);
        while (estimate_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/wape_pkg.sv
hw/rtl/wape_lookup.sv
hw/rtl/wape_interp.sv
hw/rtl/wape_scale.sv
hw/rtl/wifi_action_per_estimator_unit.sv
hw/rtl/wape_checker.sv
test/wifi_action_per_estimator_unit_test.sv
